>>> rtl/dbss_pkg.sv
// Shared types, constants and helper functions for the dual blower start supervisor.
// Used by dbss_channel and dual_blower_start_supervisor; depends on nothing.
package dbss_pkg;

   // Per-channel machine state, also reported on the result bus
   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_START = 2'd1,
      MODE_TEST  = 2'd2,
      MODE_RUN   = 2'd3
   } mode_type;

   // What the PWM stage does with a channel's held duty value
   typedef enum logic [1:0] {
      PWM_KEEP  = 2'd0,
      PWM_ZERO  = 2'd1,
      PWM_IDLE  = 2'd2,
      PWM_SCALE = 2'd3
   } pwm_cmd_type;

   // Request opcodes carried on tuser
   typedef enum logic {
      OP_SET_SPEED = 1'b0,
      OP_TICK      = 1'b1
   } opcode_type;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PWM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEST_DELAY = 2'd2;

   // Register reset values
   localparam logic [15:0] FULL_SCALE_RST = 16'd62059;
   localparam logic [15:0] IDLE_PWM_RST   = 16'd10;
   localparam logic [7:0]  TEST_DELAY_RST = 8'd15;

   // Field widths
   localparam int unsigned PWM_W   = 16;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned CNT_W   = 9;
   localparam int unsigned DELAY_W = 8;
   localparam int unsigned PROD_W  = PWM_W + PCT_W;

   // Exact floor(x / 100) for x < 2**PROD_W: (x * RECIP) >> RECIP_SHIFT
   localparam int unsigned RECIP_SHIFT = 30;
   localparam int unsigned RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
   localparam int unsigned WIDE_W = PROD_W + RECIP_W;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
   localparam logic [CNT_W-1:0] CNT_SAT = '1;

   // Channel control outputs handed to the PWM pipeline
   typedef struct packed {
      pwm_cmd_type             cmd;
      logic [PCT_W-1:0]        pct;
      logic                    enable;
      mode_type                mode;
      logic                    on;
   } chan_out_type;

   // Round a clipped percent to the nearest multiple of 5 (remainders 3, 4 go up).
   // floor((c + 2) / 5) via multiply by 205 / 1024, exact for c up to 100.
   function automatic logic [PCT_W-1:0] round5(input logic [PCT_W-1:0] c);
      logic [7:0]       sum;
      logic [15:0]      prod;
      logic [PCT_W-1:0] q;
      sum  = {1'b0, c} + 8'd2;
      prod = 16'(sum) * 16'd205;
      q    = {2'b00, prod[14:10]};
      return 7'(q << 2) + q;
   endfunction

   // Running-speed remap of the upper range
   function automatic logic [PCT_W-1:0] remap(input logic [PCT_W-1:0] pct);
      logic [PCT_W-1:0] res;
      case (pct)
         7'd80:   res = 7'd77;
         7'd85:   res = 7'd79;
         7'd90:   res = 7'd81;
         7'd95:   res = 7'd83;
         7'd100:  res = 7'd85;
         default: res = pct;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/dbss_channel.sv
// One blower channel: speed request, on flag and the off/start/test/running machine.
// Uses dbss_pkg for the mode and PWM command types and the rounding helpers.
module dbss_channel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          set_sel,      // set-speed request for this channel
   input  logic                          tick,         // control tick request
   input  logic [7:0]                    speed_percent,
   input  logic                          fault,
   input  logic [dbss_pkg::DELAY_W-1:0]  test_delay,
   output dbss_pkg::chan_out_type        chan_o
);

   dbss_pkg::mode_type               mode_ff, mode_in, cur_mode;
   logic                             on_ff, on_in;
   logic [dbss_pkg::PCT_W-1:0]       speed_ff, speed_in;
   logic [dbss_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             enable_ff, enable_in;
   logic [dbss_pkg::PCT_W-1:0]       clip_pct;
   dbss_pkg::pwm_cmd_type            cmd;
   logic [dbss_pkg::PCT_W-1:0]       pct;

   // Clip the request to 100 percent
   assign clip_pct = (speed_percent > 8'(dbss_pkg::PCT_MAX)) ? dbss_pkg::PCT_MAX
                                                             : speed_percent[6:0];

   // Next state for one request
   always_comb begin
      mode_in   = mode_ff;
      on_in     = on_ff;
      speed_in  = speed_ff;
      count_in  = count_ff;
      enable_in = enable_ff;
      cmd       = dbss_pkg::PWM_KEEP;
      pct       = speed_ff;
      cur_mode  = mode_ff;
      if (set_sel) begin
         speed_in = dbss_pkg::round5(clip_pct);
         if (speed_percent == 8'd0) begin
            on_in   = 1'b0;
            mode_in = dbss_pkg::MODE_OFF;
         end else begin
            on_in = 1'b1;
            if (mode_ff == dbss_pkg::MODE_OFF) begin
               mode_in = dbss_pkg::MODE_START;
            end
         end
      end else if (tick) begin
         if (!on_ff) begin
            cmd       = dbss_pkg::PWM_ZERO;
            enable_in = 1'b0;
            mode_in   = dbss_pkg::MODE_OFF;
         end else begin
            // a fault while running restarts the channel
            if (fault && mode_ff == dbss_pkg::MODE_RUN) begin
               cur_mode = dbss_pkg::MODE_START;
            end
            mode_in = cur_mode;
            case (cur_mode)
               dbss_pkg::MODE_OFF: begin
                  cmd       = dbss_pkg::PWM_IDLE;
                  enable_in = 1'b0;
               end
               dbss_pkg::MODE_START: begin
                  enable_in = 1'b1;
                  count_in  = '0;
                  mode_in   = dbss_pkg::MODE_TEST;
               end
               dbss_pkg::MODE_TEST: begin
                  if (count_ff != dbss_pkg::CNT_SAT) begin
                     count_in = count_ff + dbss_pkg::CNT_W'(1);
                  end
                  if (count_ff > dbss_pkg::CNT_W'(test_delay)) begin
                     if (fault) begin
                        enable_in = 1'b0;
                        cmd       = dbss_pkg::PWM_IDLE;
                        mode_in   = dbss_pkg::MODE_START;
                     end else begin
                        cmd     = dbss_pkg::PWM_SCALE;
                        mode_in = dbss_pkg::MODE_RUN;
                     end
                  end
               end
               default: begin
                  speed_in = dbss_pkg::remap(speed_ff);
                  pct      = speed_in;
                  cmd      = dbss_pkg::PWM_SCALE;
               end
            endcase
         end
      end
   end

   // Hold channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dbss_pkg::MODE_OFF;
         on_ff     <= 1'b0;
         speed_ff  <= '0;
         count_ff  <= '0;
         enable_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         on_ff     <= on_in;
         speed_ff  <= speed_in;
         count_ff  <= count_in;
         enable_ff <= enable_in;
      end
   end

   assign chan_o.cmd    = cmd;
   assign chan_o.pct    = pct;
   assign chan_o.enable = enable_in;
   assign chan_o.mode   = mode_in;
   assign chan_o.on     = on_in;

endmodule

>>> rtl/dual_blower_start_supervisor.sv
// Dual blower start supervisor top level: request/response streams, settings, PWM scaling.
// Pipeline: control into stage one, multiply into stage two, /100 into the response register.
// Throughput: one request per cycle unless the response side stalls (req_tready then drops);
// the control state updates in the accept cycle.
// Reset (synchronous, active high): both channels off, settings at defaults, pipeline empty.
// Depends on dbss_pkg and dbss_channel.
module dual_blower_start_supervisor (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // channel, speed_percent[7:0],
                                                         // top_fault, bottom_fault, zero pad
   input  logic                              req_tuser,  // opcode
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // top_pwm[15:0], top_enable,
                                                         // top_mode[1:0], top_on, bottom_pwm,
                                                         // bottom_enable, bottom_mode, bottom_on
   // settings write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dbss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_data
);

   localparam int unsigned NUM_CH = 2;

   logic [dbss_pkg::PWM_W-1:0]   full_scale_ff, idle_pwm_ff;
   logic [dbss_pkg::DELAY_W-1:0] test_delay_ff;

   logic                         accept;
   logic                         adv1, adv2, adv3, load3;
   logic [NUM_CH-1:0]            fault;
   logic [NUM_CH-1:0]            set_sel;
   logic                         tick;

   dbss_pkg::chan_out_type       chan_o [NUM_CH];
   logic                         v1_ff, v2_ff, rsp_valid_ff;
   dbss_pkg::chan_out_type       s1_ff  [NUM_CH];
   dbss_pkg::chan_out_type       s2_ff  [NUM_CH];
   logic [dbss_pkg::PROD_W-1:0]  prod_ff [NUM_CH];
   logic [dbss_pkg::PROD_W-1:0]  prod_in [NUM_CH];
   dbss_pkg::chan_out_type       s3_ff  [NUM_CH];
   logic [dbss_pkg::PWM_W-1:0]   pwm_ff [NUM_CH];
   logic [dbss_pkg::PWM_W-1:0]   pwm_in [NUM_CH];
   logic [dbss_pkg::WIDE_W-1:0]  quot_wide [NUM_CH];

   // Settings writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= dbss_pkg::FULL_SCALE_RST;
         idle_pwm_ff   <= dbss_pkg::IDLE_PWM_RST;
         test_delay_ff <= dbss_pkg::TEST_DELAY_RST;
      end else if (csr_valid) begin
         case (csr_index)
            dbss_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_data;
            dbss_pkg::CSR_IDLE_PWM:   idle_pwm_ff   <= csr_data;
            dbss_pkg::CSR_TEST_DELAY: test_delay_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Stage advance: each stage moves when empty or when the next one moves
   assign adv3       = !rsp_valid_ff || rsp_tready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign load3      = adv3 && v2_ff;
   assign req_tready = adv1;
   assign accept     = req_tvalid && req_tready;

   // Decode the request
   assign tick       = accept && (req_tuser == dbss_pkg::OP_TICK);
   assign set_sel[0] = accept && (req_tuser == dbss_pkg::OP_SET_SPEED) && !req_tdata[0];
   assign set_sel[1] = accept && (req_tuser == dbss_pkg::OP_SET_SPEED) && req_tdata[0];
   assign fault[0]   = req_tdata[9];
   assign fault[1]   = req_tdata[10];

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
      dbss_channel u_channel (
         .clock         (clock),
         .reset         (reset),
         .set_sel       (set_sel[ch]),
         .tick          (tick),
         .speed_percent (req_tdata[8:1]),
         .fault         (fault[ch]),
         .test_delay    (test_delay_ff),
         .chan_o        (chan_o[ch])
      );

      // Scale by full scale, then divide by 100 with a reciprocal multiply
      assign prod_in[ch]   = dbss_pkg::PROD_W'(full_scale_ff) * dbss_pkg::PROD_W'(s1_ff[ch].pct);
      assign quot_wide[ch] = dbss_pkg::WIDE_W'(prod_ff[ch])
                             * dbss_pkg::WIDE_W'(dbss_pkg::RECIP_100);

      // Apply the PWM command to the held duty value
      always_comb begin
         case (s2_ff[ch].cmd)
            dbss_pkg::PWM_ZERO:  pwm_in[ch] = '0;
            dbss_pkg::PWM_IDLE:  pwm_in[ch] = idle_pwm_ff;
            dbss_pkg::PWM_SCALE: pwm_in[ch] =
               quot_wide[ch][dbss_pkg::RECIP_SHIFT +: dbss_pkg::PWM_W];
            default:             pwm_in[ch] = pwm_ff[ch];
         endcase
      end

      // Advance the payload through the stages
      always_ff @(posedge clock) begin
         if (adv1) begin
            s1_ff[ch] <= chan_o[ch];
         end
         if (adv2) begin
            s2_ff[ch]   <= s1_ff[ch];
            prod_ff[ch] <= prod_in[ch];
         end
         if (load3) begin
            s3_ff[ch] <= s2_ff[ch];
         end
      end

      // Held duty value doubles as the response PWM field
      always_ff @(posedge clock) begin
         if (reset) begin
            pwm_ff[ch] <= '0;
         end else if (load3) begin
            pwm_ff[ch] <= pwm_in[ch];
         end
      end
   end

   // Track stage occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= accept;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {s3_ff[1].on, s3_ff[1].mode, s3_ff[1].enable, pwm_ff[1],
                        s3_ff[0].on, s3_ff[0].mode, s3_ff[0].enable, pwm_ff[0]};

`ifndef SYNTHESIS
   // An accepted request always occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   // The top channel, when not requested on, is always reported off
   a_off_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !s3_ff[0].on) |-> (s3_ff[0].mode == dbss_pkg::MODE_OFF))
      else $error("top channel not off while not requested");

   // Scaled PWM on the bottom channel only comes out of the running state
   a_scale_running: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && s1_ff[1].cmd == dbss_pkg::PWM_SCALE) |-> (s1_ff[1].mode == dbss_pkg::MODE_RUN))
      else $error("bottom channel scaled PWM outside running state");

   // Zeroing the top channel's PWM goes with a disabled, unrequested channel
   a_zero_disabled: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && s1_ff[0].cmd == dbss_pkg::PWM_ZERO) |-> (!s1_ff[0].enable && !s1_ff[0].on))
      else $error("top channel PWM zeroed while enabled or requested");

   // A held response keeps its PWM value
   a_pwm_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(pwm_ff[0]) && $stable(pwm_ff[1]))
      else $error("PWM changed while response stalled");
`endif

endmodule

>>> tb/sv/dbss_status_checker.sv
`timescale 1ns / 100ps
// Status checker for the dual blower start supervisor: watches the request, response and
// settings channels, predicts the status of both blowers and compares it field by field.
// Depends on dbss_pkg for the mode, opcode and register index codes.
module dbss_status_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // channel, speed_percent[7:0],
                                                       // top_fault, bottom_fault, zero pad
   input  logic                           req_tuser,   // opcode
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [39:0]                    rsp_tdata,   // top_pwm[15:0], top_enable,
                                                       // top_mode[1:0], top_on, bottom_pwm,
                                                       // bottom_enable, bottom_mode, bottom_on
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [dbss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data,
   output int                             awaited_count,
   output int                             fail_count
);

   // One blower's status as it sits on the response bus, pwm in the low bits
   typedef struct packed {
      logic               on;
      dbss_pkg::mode_type mode;
      logic               enable;
      logic [15:0]        pwm;
   } blower_view_type;

   // Index 0 is the top blower, index 1 the bottom one
   typedef blower_view_type [1:0] status_pair_type;

   status_pair_type predicted_status_q[$];

   // Predicted blower state
   dbss_pkg::mode_type blower_mode[2];
   logic               blower_on[2];
   logic [6:0]         speed_pct[2];
   logic [8:0]         test_count[2];
   logic [15:0]        pwm_level[2];
   logic               enable_level[2];

   // Predicted settings
   logic [15:0] full_scale;
   logic [15:0] idle_level;
   logic [7:0]  pass_delay;

   function automatic logic [15:0] scaled_duty(logic [6:0] pct);
      logic [31:0] prod;
      prod = 32'(full_scale) * 32'(pct);
      return 16'(prod / 32'd100);
   endfunction

   // Upper speeds are pulled down once the blower runs
   function automatic logic [6:0] running_pct(logic [6:0] pct);
      case (pct)
         7'd80:   return 7'd77;
         7'd85:   return 7'd79;
         7'd90:   return 7'd81;
         7'd95:   return 7'd83;
         7'd100:  return 7'd85;
         default: return pct;
      endcase
   endfunction

   // Store a new speed: clip to 100, round to a multiple of 5 (3 and 4 go up)
   function automatic void apply_speed(int ch, logic [7:0] raw);
      int unsigned pct;
      int unsigned rem;
      if (raw == 8'd0) begin
         blower_on[ch]   = 1'b0;
         blower_mode[ch] = dbss_pkg::MODE_OFF;
      end else begin
         blower_on[ch] = 1'b1;
         if (blower_mode[ch] == dbss_pkg::MODE_OFF)
            blower_mode[ch] = dbss_pkg::MODE_START;
      end
      pct = (raw > 8'd100) ? 100 : int'(raw);
      rem = pct % 5;
      pct = (rem > 2) ? pct + 5 - rem : pct - rem;
      speed_pct[ch] = 7'(pct);
   endfunction

   // Advance one blower's start machine on a control tick
   function automatic void advance_blower(int ch, logic fault);
      logic [8:0] prior;
      if (!blower_on[ch]) begin
         pwm_level[ch]    = '0;
         enable_level[ch] = 1'b0;
         blower_mode[ch]  = dbss_pkg::MODE_OFF;
         return;
      end
      if (fault && blower_mode[ch] == dbss_pkg::MODE_RUN)
         blower_mode[ch] = dbss_pkg::MODE_START;
      case (blower_mode[ch])
         dbss_pkg::MODE_OFF: begin
            pwm_level[ch]    = idle_level;
            enable_level[ch] = 1'b0;
         end
         dbss_pkg::MODE_START: begin
            enable_level[ch] = 1'b1;
            test_count[ch]   = '0;
            blower_mode[ch]  = dbss_pkg::MODE_TEST;
         end
         dbss_pkg::MODE_TEST: begin
            prior = test_count[ch];
            if (prior != 9'h1FF)
               test_count[ch] = prior + 9'd1;
            if (prior > {1'b0, pass_delay}) begin
               if (fault) begin
                  enable_level[ch] = 1'b0;
                  pwm_level[ch]    = idle_level;
                  blower_mode[ch]  = dbss_pkg::MODE_START;
               end else begin
                  blower_mode[ch] = dbss_pkg::MODE_RUN;
                  pwm_level[ch]   = scaled_duty(speed_pct[ch]);
               end
            end
         end
         default: begin
            speed_pct[ch] = running_pct(speed_pct[ch]);
            pwm_level[ch] = scaled_duty(speed_pct[ch]);
         end
      endcase
   endfunction

   function automatic void check_blower(string side, blower_view_type want,
                                        blower_view_type got);
      if (got.pwm !== want.pwm) begin
         $error("%s_pwm expected %0d actual %0d", side, want.pwm, got.pwm);
         fail_count++;
      end
      if (got.enable !== want.enable) begin
         $error("%s_enable expected %0d actual %0d", side, want.enable, got.enable);
         fail_count++;
      end
      if (got.mode !== want.mode) begin
         $error("%s_mode expected %0d actual %0d", side, want.mode, got.mode);
         fail_count++;
      end
      if (got.on !== want.on) begin
         $error("%s_on expected %0d actual %0d", side, want.on, got.on);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : track
      status_pair_type snap;
      status_pair_type want;
      if (reset) begin
         full_scale = dbss_pkg::FULL_SCALE_RST;
         idle_level = dbss_pkg::IDLE_PWM_RST;
         pass_delay = dbss_pkg::TEST_DELAY_RST;
         for (int ch = 0; ch < 2; ch++) begin
            blower_mode[ch]  = dbss_pkg::MODE_OFF;
            blower_on[ch]    = 1'b0;
            speed_pct[ch]    = '0;
            test_count[ch]   = '0;
            pwm_level[ch]    = '0;
            enable_level[ch] = 1'b0;
         end
         predicted_status_q.delete();
         awaited_count <= 0;
      end else begin
         // Take a settings write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dbss_pkg::CSR_FULL_SCALE: full_scale = csr_data;
               dbss_pkg::CSR_IDLE_PWM:   idle_level = csr_data;
               dbss_pkg::CSR_TEST_DELAY: pass_delay = csr_data[7:0];
               default: ;
            endcase
         end

         // Compare a response with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_status_q.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = predicted_status_q.pop_front();
               snap = status_pair_type'(rsp_tdata);
               check_blower("top", want[0], snap[0]);
               check_blower("bottom", want[1], snap[1]);
            end
         end

         // Predict the status after an accepted request
         if (req_tvalid && req_tready) begin
            if (dbss_pkg::opcode_type'(req_tuser) == dbss_pkg::OP_TICK) begin
               advance_blower(0, req_tdata[9]);
               advance_blower(1, req_tdata[10]);
            end else begin
               apply_speed(int'(req_tdata[0]), req_tdata[8:1]);
            end
            for (int ch = 0; ch < 2; ch++) begin
               snap[ch].pwm    = pwm_level[ch];
               snap[ch].enable = enable_level[ch];
               snap[ch].mode   = blower_mode[ch];
               snap[ch].on     = blower_on[ch];
            end
            predicted_status_q.push_back(snap);
         end

         awaited_count <= predicted_status_q.size();
      end
   end

endmodule

>>> tb/sv/dual_blower_start_supervisor_tb.sv
`timescale 1ns / 100ps
// Top of the dual blower start supervisor testbench: clock, reset, request and settings
// stimulus, response back-pressure, watchdog and verdict. Needs dbss_pkg, the block and
// dbss_status_checker.
module dual_blower_start_supervisor_tb;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic [15:0]                    req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tready = 1'b0;
   logic                           csr_valid  = 1'b0;
   logic [dbss_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]                    csr_data   = '0;
   wire                            req_tready;
   wire                            rsp_tvalid;
   wire  [39:0]                    rsp_tdata;
   wire                            csr_ready;

   int awaited_count;
   int fail_count;
   int quiet_cycles;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_armed     = 1'b0;

   always #1 clock = ~clock;

   dual_blower_start_supervisor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dbss_status_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .awaited_count (awaited_count),
      .fail_count    (fail_count)
   );

   // Abort when no channel moves anything for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[dual_blower_start_supervisor] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: ready stretches, short stall bursts, one long hold-off on demand
   initial begin
      @(posedge clock);
      forever begin
         if (hold_armed) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_armed = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offer one request, with an optional idle burst first; valid stays high afterwards
   task automatic send_request(input dbss_pkg::opcode_type op, input logic ch,
                               input logic [7:0] pct, input logic top_fault,
                               input logic bottom_fault);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, bottom_fault, top_fault, pct, ch};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [dbss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (last)
         csr_valid <= 1'b0;
   endtask

   // Stop offering and hold until every predicted status has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   task automatic program_settings(input logic [15:0] scale, input logic [15:0] idle,
                                   input logic [7:0] delay);
      settle();
      write_reg(dbss_pkg::CSR_FULL_SCALE, scale, 1'b0);
      write_reg(dbss_pkg::CSR_IDLE_PWM, idle, 1'b0);
      write_reg(dbss_pkg::CSR_TEST_DELAY, {8'd0, delay}, 1'b1);
   endtask

   // Random traffic: mostly ticks that walk the machines, speed sets with all ranges
   task automatic run_traffic(input int count, input int tick_pct, input int zero_pct,
                              input int fault_odds);
      int          pick;
      logic [7:0]  pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(1, 100) <= tick_pct) begin
            send_request(dbss_pkg::OP_TICK, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)),
                         $urandom_range(1, fault_odds) == 1,
                         $urandom_range(1, fault_odds) == 1);
         end else begin
            pick = $urandom_range(1, 100);
            if (pick <= zero_pct)
               pct = 8'd0;
            else if (pick <= zero_pct + 70)
               pct = 8'($urandom_range(1, 100));
            else
               pct = 8'($urandom_range(101, 255));
            send_request(dbss_pkg::OP_SET_SPEED, 1'($urandom_range(0, 1)), pct,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Short test window so the directed part reaches the running state
      write_reg(dbss_pkg::CSR_TEST_DELAY, 16'd0, 1'b1);

      // Directed: unrequested tick, off, clipping, rounding both ways, retry, remap,
      // fault while running, ignored fields
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b1, 1'b1);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b0, 8'd255, 1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b1, 8'd3,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b1, 8'd1,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b1, 8'd8,   1'b1, 1'b1);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b1, 8'd255, 1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b1, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b1, 1'b1);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b1, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b0, 8'd99,  1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b0, 8'd0,   1'b0, 1'b0);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b0, 8'd42,  1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b1);
      send_request(dbss_pkg::OP_SET_SPEED, 1'b1, 8'd130, 1'b1, 1'b1);
      send_request(dbss_pkg::OP_TICK,      1'b1, 8'd170, 1'b0, 1'b0);
      send_request(dbss_pkg::OP_TICK,      1'b0, 8'd0,   1'b0, 1'b0);

      // Full-scale settings; the response side holds off while requests keep coming
      program_settings(16'hFFFF, 16'hFFFF, 8'd0);
      hold_armed = 1'b1;
      run_traffic(180, 60, 10, 8);

      // All-zero full scale and idle PWM settings, test delay of 1
      program_settings(16'h0000, 16'h0000, 8'd1);
      run_traffic(120, 60, 10, 6);

      // Random settings with short test windows
      program_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(2, 20)));
      run_traffic(180, 65, 8, 8);

      // Longest test window, no idling on either side
      program_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       8'd255);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      run_traffic(400, 95, 0, 40);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[dual_blower_start_supervisor] OK");
      else
         $display("[dual_blower_start_supervisor] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/dbss_pkg.sv
rtl/dbss_channel.sv
rtl/dual_blower_start_supervisor.sv
tb/sv/dbss_status_checker.sv
tb/sv/dual_blower_start_supervisor_tb.sv
